FILE: rtl/core/xbr_pkg.sv
`timescale 1ns / 1ps

package xbr_pkg;

  localparam int unsigned RangeWidth = 31;
  localparam int unsigned SeedWidth  = 32;
  localparam int unsigned StateWidth = 64;
  localparam int unsigned DrawWidth  = 32;

  localparam int unsigned ShiftA = 21;
  localparam int unsigned ShiftB = 35;
  localparam int unsigned ShiftC = 4;

  typedef struct packed {
    logic [RangeWidth-1:0] range_min;
    logic [RangeWidth-1:0] range_max;
    logic                  restart;
  } xbr_in_t;

  typedef struct packed {
    logic [RangeWidth-1:0] value;
    logic                  failed;
  } xbr_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } xbr_rng_cmd_t;

  function automatic logic [StateWidth-1:0] xorshift_advance(input logic [StateWidth-1:0] s);
    logic [StateWidth-1:0] t;
    t = s ^ (s << ShiftA);
    t = t ^ (t >> ShiftB);
    t = t ^ (t << ShiftC);
    return t;
  endfunction

endpackage

FILE: rtl/core/xbr_rng.sv
`timescale 1ns / 1ps

module xbr_rng
  import xbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  xbr_rng_cmd_t          cmd,
  input  logic [SeedWidth-1:0]  seed,
  output logic [DrawWidth-1:0]  draw_mag
);

  logic [StateWidth-1:0] rng_state;
  logic [DrawWidth-1:0]  low_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state <= '0;
    end else if (cmd.load) begin
      rng_state <= {{(StateWidth-SeedWidth){1'b0}}, seed};
    end else if (cmd.step) begin
      rng_state <= xorshift_advance(rng_state);
    end
  end

  // magnitude of the signed low word
  assign low_word = rng_state[DrawWidth-1:0];
  assign draw_mag = low_word[DrawWidth-1] ? (~low_word + DrawWidth'(1)) : low_word;

endmodule

FILE: rtl/core/xbr_rem.sv
`timescale 1ns / 1ps

module xbr_rem
  import xbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DrawWidth-1:0]  dividend,
  input  logic [DrawWidth-1:0]  divisor,
  output logic                  done,
  output logic [RangeWidth-1:0] rem
);

  localparam int unsigned CntWidth = $clog2(DrawWidth);

  logic                  busy;
  logic [CntWidth-1:0]   count;
  logic [DrawWidth-1:0]  shift_q;
  logic [DrawWidth-1:0]  divisor_q;
  logic [DrawWidth-1:0]  trial;
  logic [RangeWidth-1:0] rem_next;

  // one restoring step per cycle
  always_comb begin
    trial = {rem, shift_q[DrawWidth-1]};
    if (trial >= divisor_q) begin
      rem_next = RangeWidth'(trial - divisor_q);
    end else begin
      rem_next = trial[RangeWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CntWidth'(1);
        if (count == CntWidth'(DrawWidth - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_q   <= dividend;
      divisor_q <= divisor;
      rem       <= '0;
    end else if (busy) begin
      shift_q <= {shift_q[DrawWidth-2:0], 1'b0};
      rem     <= rem_next;
    end
  end

endmodule

FILE: rtl/core/xorshift_bounded_random.sv
`timescale 1ns / 1ps
// one transaction in, one transaction out; the input is stalled while a request is in work
// each draw runs one state advance, one divider load, 32 remainder steps and one check, in that order
// a request makes from 1 to MAX_TRIES draws; an empty range makes none and returns a failed result
// the 32-step shared remainder unit paces each draw; the next request enters once the result is taken
// reset clears generator state and the seeded flag and sets the seed register to 1

module xorshift_bounded_random
  import xbr_pkg::*;
#(
  parameter int unsigned MAX_TRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 seed_wr_en,
  input  logic [SeedWidth-1:0] seed_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xbr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xbr_out_t             out_data
);

  localparam int unsigned TryWidth = $clog2(MAX_TRIES + 1);
  localparam logic [TryWidth-1:0] TryLimit = TryWidth'(MAX_TRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEP  = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } xbr_state_t;

  xbr_state_t state;
  xbr_state_t state_next;

  logic [SeedWidth-1:0]  seed;
  logic                  seeded;
  logic [RangeWidth-1:0] range_min;
  logic [RangeWidth-1:0] range_max;
  logic [TryWidth-1:0]   tries;
  logic [TryWidth-1:0]   tries_next;
  xbr_out_t              result;

  xbr_rng_cmd_t          rng_cmd;
  logic [DrawWidth-1:0]  draw_mag;
  logic                  rem_start;
  logic                  rem_done;
  logic [RangeWidth-1:0] rem;
  logic [DrawWidth-1:0]  modulus;
  logic                  in_accept;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_data  = result;
  assign modulus   = {1'b0, range_max} + DrawWidth'(1);
  assign rem_start = (state == S_START);
  assign tries_next = tries + TryWidth'(1);

  assign rng_cmd.load = in_accept && (in_data.restart || !seeded);
  assign rng_cmd.step = (state == S_STEP);

  xbr_rng u_rng (
    .clk      (clk),
    .rst      (rst),
    .cmd      (rng_cmd),
    .seed     (seed),
    .draw_mag (draw_mag)
  );

  xbr_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (draw_mag),
    .divisor  (modulus),
    .done     (rem_done),
    .rem      (rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.range_min > in_data.range_max) begin
            state_next = S_DONE;
          end else begin
            state_next = S_STEP;
          end
        end
      end
      S_STEP:  state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT: begin
        if (rem_done) begin
          if (rem >= range_min || tries_next == TryLimit) begin
            state_next = S_DONE;
          end else begin
            state_next = S_STEP;
          end
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      seed   <= SeedWidth'(1);
      seeded <= 1'b0;
      tries  <= '0;
    end else begin
      state <= state_next;
      if (seed_wr_en) begin
        seed <= seed_wr_data;
      end
      if (rng_cmd.load) begin
        seeded <= 1'b1;
      end
      if (in_accept) begin
        tries <= '0;
      end else if (state == S_WAIT && rem_done) begin
        tries <= tries_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      range_min     <= in_data.range_min;
      range_max     <= in_data.range_max;
      result.value  <= '0;
      result.failed <= 1'b1;
    end else if (state == S_WAIT && rem_done && rem >= range_min) begin
      result.value  <= rem;
      result.failed <= 1'b0;
    end
  end

endmodule
